// ===== sv/iee_pkg.sv =====
// ----------------------------------------------------------------------------
// iee_pkg
// types and constants shared by the infix expression evaluator
// ----------------------------------------------------------------------------
package iee_pkg;

    localparam int NEST_DEPTH_DEF  = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int OUT_WIDTH       = 32;

    typedef enum logic [1:0] {
        OP_PLUS   = 2'd0,
        OP_MINUS  = 2'd1,
        OP_TIMES  = 2'd2,
        OP_DIVIDE = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_DIVZERO   = 2'd1,
        ST_DEEP      = 2'd2,
        ST_UNMATCHED = 2'd3
    } t_status;

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_TIMES = 8'h2A;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [3:0] {
        S_IDLE,
        S_APPLY,
        S_DIVWAIT,
        S_FOLD,
        S_POPRD,
        S_POP,
        S_FINAL,
        S_FINWAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
        logic busy;
    } t_div_ctl;

endpackage

// ===== sv/iee_div.sv =====
// ----------------------------------------------------------------------------
// iee_div
// radix-2 restoring divider, signed with truncation toward zero
// ----------------------------------------------------------------------------
module iee_div #(
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [VALUE_WIDTH-1:0] i_num,
    input  logic [VALUE_WIDTH-1:0] i_den,
    output iee_pkg::t_div_ctl      o_ctl,
    output logic [VALUE_WIDTH-1:0] o_quot
);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [VALUE_WIDTH-1:0] r_q, n_q;
    logic [VALUE_WIDTH-1:0] r_d, n_d;
    logic [VALUE_WIDTH:0]   r_rem, n_rem;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic                   r_neg, n_neg;
    logic                   r_busy, n_busy;
    logic [VALUE_WIDTH:0]   w_sh;

    always_comb begin
        n_q    = r_q;
        n_d    = r_d;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_neg  = r_neg;
        n_busy = r_busy;
        w_sh   = {r_rem[VALUE_WIDTH-1:0], r_q[VALUE_WIDTH-1]};
        if (i_start) begin
            n_q    = i_num[VALUE_WIDTH-1] ? (~i_num + 1'b1) : i_num;
            n_d    = i_den[VALUE_WIDTH-1] ? (~i_den + 1'b1) : i_den;
            n_neg  = i_num[VALUE_WIDTH-1] ^ i_den[VALUE_WIDTH-1];
            n_rem  = '0;
            n_cnt  = CW'(VALUE_WIDTH);
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (w_sh >= {1'b0, r_d}) begin
                n_rem = w_sh - {1'b0, r_d};
                n_q   = {r_q[VALUE_WIDTH-2:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_q   = {r_q[VALUE_WIDTH-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_q   <= n_q;
        r_d   <= n_d;
        r_rem <= n_rem;
        r_neg <= n_neg;
    end

    assign o_ctl.start = i_start;
    assign o_ctl.busy  = r_busy;
    assign o_quot      = r_neg ? (~r_q + 1'b1) : r_q;
endmodule

// ===== sv/iee_stack.sv =====
// ----------------------------------------------------------------------------
// iee_stack
// nesting stack memory: saved sum, term and operator, registered read
// ----------------------------------------------------------------------------
module iee_stack #(
    parameter int NEST_DEPTH  = iee_pkg::NEST_DEPTH_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF,
    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1,
    localparam int DW = 2 * VALUE_WIDTH + 2
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [DW-1:0] i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [DW-1:0] o_rdata
);
    logic [DW-1:0] r_mem [NEST_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== sv/infix_expression_evaluator.sv =====
// steps: a digit, an open parenthesis or any other character is taken in IDLE;
// +, -, * and / pass through APPLY and FOLD, ) through APPLY, FOLD, POPRD and
// POP, and a step that divides by a nonzero number waits in DIVWAIT on the
// radix-2 divider; the last character adds a fold and a result beat, and after )
// or an operator FINAL, FINWAIT, APPLY, FOLD and OUT; one character at a time, OUT holds until taken;
// reset clears all accumulators, nesting and status
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// character-serial evaluator of + - * / with precedence and parentheses
// ----------------------------------------------------------------------------
module infix_expression_evaluator #(
    parameter int NEST_DEPTH  = iee_pkg::NEST_DEPTH_DEF,
    parameter int VALUE_WIDTH = iee_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // value[31:0], status[33:32], zero pad
);
    localparam int VW = VALUE_WIDTH;
    localparam int AW = (NEST_DEPTH > 1) ? $clog2(NEST_DEPTH) : 1;
    localparam int LW = $clog2(NEST_DEPTH + 1);
    localparam int DW = 2 * VW + 2;
    localparam int OW = iee_pkg::OUT_WIDTH;

    localparam logic [1:0] K_OP     = 2'd0;
    localparam logic [1:0] K_CLOSE  = 2'd1;
    localparam logic [1:0] K_FINAL  = 2'd2;
    localparam logic [1:0] K_OPLAST = 2'd3;

    iee_pkg::t_state r_state, n_state;
    logic [VW-1:0]  r_num, n_num, r_term, n_term, r_sum, n_sum;
    iee_pkg::t_op   r_op, n_op, r_nop, n_nop;
    logic [LW-1:0]  r_lvl, n_lvl;
    iee_pkg::t_status r_err, n_err;
    logic [1:0]     r_kind, n_kind;     // op, close, final, op as last
    logic           r_addsum, n_addsum, r_last, n_last;
    logic [VW-1:0]  r_prod;
    logic [OW-1:0]  r_oval, n_oval;
    logic [1:0]     r_ost, n_ost;

    logic           w_we, w_dstart;
    logic [AW-1:0]  w_waddr, w_raddr;
    logic [DW-1:0]  w_wdata, w_rdata;
    iee_pkg::t_div_ctl w_dctl;
    logic [VW-1:0]  w_quot, w_applied;
    logic           w_acc, w_isdig, w_isop;
    logic [7:0]     w_c;

    iee_stack #(.NEST_DEPTH(NEST_DEPTH), .VALUE_WIDTH(VW)) u_stack (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rdata)
    );

    iee_div #(.VALUE_WIDTH(VW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_dstart),
        .i_num(r_term), .i_den(r_num), .o_ctl(w_dctl), .o_quot(w_quot)
    );

    assign w_c    = s_axis_tdata;
    assign w_acc  = s_axis_tvalid && s_axis_tready;
    assign w_isdig = (w_c >= iee_pkg::CH_ZERO) && (w_c <= iee_pkg::CH_NINE);
    assign w_isop = (w_c == iee_pkg::CH_PLUS) || (w_c == iee_pkg::CH_MINUS)
                 || (w_c == iee_pkg::CH_TIMES) || (w_c == iee_pkg::CH_DIV);
    assign w_waddr = r_lvl[AW-1:0];
    assign w_wdata = {r_sum, r_term, r_op};
    assign w_raddr = r_lvl[AW-1:0];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iee_pkg::S_IDLE: begin
                if (w_acc) begin
                    if (w_isop) begin
                        n_state = iee_pkg::S_APPLY;
                    end else if (w_c == iee_pkg::CH_CLOSE && r_lvl != '0) begin
                        n_state = iee_pkg::S_APPLY;
                    end else if (s_axis_tlast) begin
                        n_state = iee_pkg::S_APPLY;
                    end
                end
            end
            iee_pkg::S_APPLY: begin
                if (r_op == iee_pkg::OP_DIVIDE && r_num != '0) begin
                    n_state = iee_pkg::S_DIVWAIT;
                end else begin
                    n_state = iee_pkg::S_FOLD;
                end
            end
            iee_pkg::S_DIVWAIT: begin
                if (!w_dctl.busy && !w_dctl.start) begin
                    n_state = iee_pkg::S_FOLD;
                end
            end
            iee_pkg::S_FOLD: begin
                unique case (r_kind)
                    K_CLOSE: n_state = iee_pkg::S_POPRD;
                    K_FINAL: n_state = iee_pkg::S_OUT;
                    default: n_state = (r_last || r_kind == K_OPLAST) ?
                                       iee_pkg::S_FINAL : iee_pkg::S_IDLE;
                endcase
            end
            iee_pkg::S_POPRD: n_state = iee_pkg::S_POP;
            iee_pkg::S_POP: n_state = r_last ? iee_pkg::S_FINAL : iee_pkg::S_IDLE;
            iee_pkg::S_FINAL: n_state = iee_pkg::S_FINWAIT;
            iee_pkg::S_FINWAIT: n_state = iee_pkg::S_APPLY;
            iee_pkg::S_OUT: if (m_axis_tready) n_state = iee_pkg::S_IDLE;
            default: n_state = iee_pkg::S_IDLE;
        endcase
    end

    // apply the pending operator to term and number
    always_comb begin
        unique case (r_op)
            iee_pkg::OP_PLUS:  w_applied = r_term + r_num;
            iee_pkg::OP_MINUS: w_applied = r_term - r_num;
            iee_pkg::OP_TIMES: w_applied = r_prod;
            default:           w_applied = (r_num == '0) ? '0 : w_quot;
        endcase
    end

    // datapath
    always_comb begin
        n_num = r_num; n_term = r_term; n_sum = r_sum; n_op = r_op;
        n_nop = r_nop; n_lvl = r_lvl; n_err = r_err; n_kind = r_kind;
        n_addsum = r_addsum; n_last = r_last; n_oval = r_oval; n_ost = r_ost;
        w_we = 1'b0;
        w_dstart = 1'b0;
        unique case (r_state)
            iee_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_last = s_axis_tlast;
                    n_kind = K_FINAL;
                    if (w_isdig) begin
                        n_num = VW'(r_num * VW'(10)) + VW'(w_c - iee_pkg::CH_ZERO);
                    end else if (w_c == iee_pkg::CH_OPEN) begin
                        if (r_lvl >= LW'(NEST_DEPTH)) begin
                            if (r_err == iee_pkg::ST_OK) n_err = iee_pkg::ST_DEEP;
                        end else begin
                            w_we = 1'b1;
                            n_lvl = r_lvl + 1'b1;
                            n_sum = '0; n_term = '0; n_num = '0;
                            n_op = iee_pkg::OP_PLUS;
                        end
                    end else if (w_c == iee_pkg::CH_CLOSE) begin
                        if (r_lvl == '0) begin
                            if (r_err == iee_pkg::ST_OK) n_err = iee_pkg::ST_UNMATCHED;
                        end else begin
                            n_kind = K_CLOSE;
                        end
                    end else if (w_isop) begin
                        n_kind = K_OP;
                        n_addsum = (w_c == iee_pkg::CH_PLUS) || (w_c == iee_pkg::CH_MINUS);
                        n_last = 1'b0;
                        if (s_axis_tlast) n_kind = K_OPLAST;
                        case (w_c)
                            iee_pkg::CH_PLUS:  n_nop = iee_pkg::OP_PLUS;
                            iee_pkg::CH_MINUS: n_nop = iee_pkg::OP_MINUS;
                            iee_pkg::CH_TIMES: n_nop = iee_pkg::OP_TIMES;
                            default:           n_nop = iee_pkg::OP_DIVIDE;
                        endcase
                    end
                end
            end
            iee_pkg::S_APPLY: begin
                if (r_op == iee_pkg::OP_DIVIDE && r_num != '0) w_dstart = 1'b1;
            end
            iee_pkg::S_FOLD: begin
                if (r_op == iee_pkg::OP_DIVIDE && r_num == '0 && r_err == iee_pkg::ST_OK)
                    n_err = iee_pkg::ST_DIVZERO;
                unique case (r_kind)
                    K_CLOSE: begin
                        n_num = r_sum + w_applied;
                        n_lvl = r_lvl - 1'b1;
                    end
                    K_FINAL: begin
                        n_sum = r_sum + w_applied;
                        n_oval = OW'($signed(r_sum + w_applied));
                        n_ost = r_err;
                        if (r_op == iee_pkg::OP_DIVIDE && r_num == '0
                            && r_err == iee_pkg::ST_OK) n_ost = iee_pkg::ST_DIVZERO;
                        if (r_lvl != '0 && n_ost == iee_pkg::ST_OK)
                            n_ost = iee_pkg::ST_UNMATCHED;
                        if (n_ost != iee_pkg::ST_OK) n_oval = '0;
                    end
                    default: begin
                        n_term = w_applied;
                        if (r_addsum) begin
                            n_sum = r_sum + w_applied;
                            n_term = '0;
                        end
                        n_op = r_nop;
                        n_num = '0;
                        // operator that is also the last character: fold once
                        if (r_kind == K_OPLAST) begin
                            n_kind = K_FINAL;
                            n_last = 1'b1;
                            n_op = iee_pkg::OP_PLUS;
                        end
                    end
                endcase
            end
            iee_pkg::S_POP: begin
                n_sum  = w_rdata[DW-1 -: VW];
                n_term = w_rdata[VW+1 -: VW];
                n_op   = iee_pkg::t_op'(w_rdata[1:0]);
                n_kind = K_FINAL;
            end
            iee_pkg::S_FINAL: begin
                // operator-last: plain fold of term into sum, number zero
                if (r_kind == K_FINAL && r_num == '0 && r_op == iee_pkg::OP_PLUS) begin
                    n_kind = K_FINAL;
                end
            end
            iee_pkg::S_OUT: begin
                if (m_axis_tready) begin
                    n_num = '0; n_term = '0; n_sum = '0; n_op = iee_pkg::OP_PLUS;
                    n_lvl = '0; n_err = iee_pkg::ST_OK; n_last = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iee_pkg::S_IDLE;
            r_num <= '0; r_term <= '0; r_sum <= '0;
            r_op <= iee_pkg::OP_PLUS; r_lvl <= '0; r_err <= iee_pkg::ST_OK;
            r_last <= 1'b0; r_kind <= K_OP;
        end else begin
            r_state <= n_state;
            r_num <= n_num; r_term <= n_term; r_sum <= n_sum;
            r_op <= n_op; r_lvl <= n_lvl; r_err <= n_err;
            r_last <= n_last; r_kind <= n_kind;
        end
        r_nop <= n_nop;
        r_addsum <= n_addsum;
        r_prod <= VW'(r_term * r_num);
        r_oval <= n_oval;
        r_ost <= n_ost;
    end

    // outputs
    always_comb begin
        s_axis_tready = (r_state == iee_pkg::S_IDLE);
        m_axis_tvalid = (r_state == iee_pkg::S_OUT);
        m_axis_tdata  = {6'd0, r_ost, r_oval};
    end
endmodule
